// File: rtl/core/imu_complementary_filter_servo_core_macros.svh
// ---------------------------------------------------------------------------
// imu_complementary_filter_servo_core_macros
// Assertion macros used by the RTL of the IMU filter core.
// ---------------------------------------------------------------------------
`ifndef IMU_COMPLEMENTARY_FILTER_SERVO_CORE_MACROS_SVH
`define IMU_COMPLEMENTARY_FILTER_SERVO_CORE_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define IMUCF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that holds at every clock edge outside reset.
`define IMUCF_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

`endif

// File: rtl/core/imucf_pkg.sv
// ---------------------------------------------------------------------------
// imucf_pkg
// Types and fixed constants of the IMU complementary filter core.
// ---------------------------------------------------------------------------
package imucf_pkg;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAL_LD,
        ST_CAL_DIV,
        ST_MUL_LD,
        ST_MUL,
        ST_INC_DIV,
        ST_FILT,
        ST_SRV_LD,
        ST_SRV_DIV,
        ST_OUT
    } t_state;

    // Serial unit lengths
    localparam int DIV_W = 42;   // dividend bits, one per cycle
    localparam int MUL_W = 20;   // elapsed_us bits, one per cycle
    localparam int CNT_W = 6;

    // Divisor width and constant divisors
    localparam int DSR_W = 23;
    localparam logic [DSR_W-1:0] INC_DEN   = 23'd250;
    localparam logic [DSR_W-1:0] SERVO_DEN = 23'd5898240;

    // Servo numerator base: 1500 * 90 * 65536
    localparam logic signed [DIV_W-1:0] SERVO_BASE = 42'sd8847360000;

    // Angle saturation limits
    localparam logic signed [35:0] ANGLE_MAX = 36'sd1073741823;
    localparam logic signed [35:0] ANGLE_MIN = -36'sd1073741824;

endpackage

// File: rtl/core/imu_complementary_filter_servo_core.sv
// ---------------------------------------------------------------------------
// imu_complementary_filter_servo_core
// Gyro/accel complementary filter with gyro offset calibration and three
// servo pulse widths derived from the filtered angles.
// ---------------------------------------------------------------------------
// One sample is worked on at a time. The first CAL_SAMPLES samples give no
// result; the last of them adds three bit-serial offset divisions. A
// calibrated sample goes, per axis, through a bit-serial multiply by
// elapsed_us, a bit-serial division by 250 and the filter update, then
// through three divisions for the servo pulses. All divisions share the
// one bit-serial divider. A new sample is taken while the previous result
// still waits in the output register.
`include "imu_complementary_filter_servo_core_macros.svh"

module imu_complementary_filter_servo_core #(
    parameter int CAL_SAMPLES = 200
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic signed [15:0] i_gyro_x,
    input  logic signed [15:0] i_gyro_y,
    input  logic signed [15:0] i_gyro_z,
    input  logic        [19:0] i_elapsed_us,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [30:0] o_roll_angle,
    output logic signed [30:0] o_pitch_angle,
    output logic signed [30:0] o_yaw_angle,
    output logic        [11:0] o_servo_first_us,
    output logic        [10:0] o_servo_second_us,
    output logic        [11:0] o_servo_third_us
);
    import imucf_pkg::*;

    // State and data registers
    t_state r_state, n_state;
    logic [1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [7:0] r_count, n_count;
    logic r_cal, n_cal;
    logic signed [15:0] r_acc [3];
    logic signed [15:0] r_gyr [3];
    logic [19:0] r_el;
    logic signed [23:0] r_sum [3], n_sum [3];
    logic signed [15:0] r_off [3], n_off [3];
    logic signed [30:0] r_ang [3], n_ang [3];
    logic signed [29:0] r_inc, n_inc;
    logic [11:0] r_s1, n_s1;
    logic [10:0] r_s2, n_s2;
    logic [11:0] r_s3, n_s3;

    // Serial multiplier
    logic signed [36:0] r_prod, n_prod, r_mcand, n_mcand;
    logic [MUL_W-1:0] r_mplr, n_mplr;

    // Serial divider
    logic [DSR_W-1:0] r_rem, n_rem, r_dsr, n_dsr;
    logic [DIV_W-1:0] r_quo, n_quo;
    logic r_neg, n_neg;

    // Output register
    logic r_ov, n_ov;
    logic signed [30:0] r_o_ang [3];
    logic [11:0] r_o_s1;
    logic [10:0] r_o_s2;
    logic [11:0] r_o_s3;
    logic w_load_out;

    logic w_take;
    logic signed [15:0] w_gyr_in [3];

    // Divider step
    logic [DSR_W:0] w_trial;
    logic w_ge;
    logic [DIV_W-1:0] w_quo_fin;
    logic signed [DIV_W-1:0] w_q;
    logic w_div_last;

    // Divider start
    logic w_start;
    logic signed [DIV_W-1:0] w_dvd;
    logic [DSR_W-1:0] w_dsr_sel;

    // Filter datapath
    logic signed [16:0] w_diff;
    logic signed [36:0] w_prod_fin;
    logic signed [35:0] w_s36, w_acc36, w_e, w_est;
    logic signed [30:0] w_sat;
    logic signed [DIV_W-1:0] w_p42, w_r42, w_srv_n;

    assign w_take = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);

    // Remap gyro axes with 16-bit wrapping negation
    assign w_gyr_in[0] = i_gyro_y;
    assign w_gyr_in[1] = 16'(-i_gyro_x);
    assign w_gyr_in[2] = 16'(-i_gyro_z);

    // One restoring division step
    assign w_trial = {r_rem, r_quo[DIV_W-1]};
    assign w_ge = (w_trial >= {1'b0, r_dsr});
    assign w_quo_fin = {r_quo[DIV_W-2:0], w_ge};
    assign w_q = r_neg ? -$signed(w_quo_fin) : $signed(w_quo_fin);
    assign w_div_last = (r_cnt == CNT_W'(DIV_W - 1));

    // Multiplier step result
    assign w_prod_fin = r_prod + (r_mplr[0] ? r_mcand : 37'sd0);
    assign w_diff = 17'(r_gyr[r_idx]) - 17'(r_off[r_idx]);

    // Filter: (3*(old+inc) + acc*23040) / 4 toward zero, saturated
    assign w_s36 = 36'(r_ang[r_idx]) + 36'(r_inc);
    assign w_acc36 = 36'(r_acc[r_idx]);
    assign w_e = (w_s36 <<< 1) + w_s36 + (w_acc36 <<< 14) + (w_acc36 <<< 12)
               + (w_acc36 <<< 11) + (w_acc36 <<< 9);
    assign w_est = (w_e + (w_e[35] ? 36'sd3 : 36'sd0)) >>> 2;
    always_comb begin
        if (w_est > ANGLE_MAX) begin
            w_sat = 31'(ANGLE_MAX);
        end else if (w_est < ANGLE_MIN) begin
            w_sat = 31'(ANGLE_MIN);
        end else begin
            w_sat = 31'(w_est);
        end
    end

    // Servo numerators
    assign w_p42 = 42'(r_ang[1]);
    assign w_r42 = 42'(r_ang[0]);
    always_comb begin
        case (r_idx)
            2'd0:    w_srv_n = SERVO_BASE + (w_p42 <<< 10) - (w_p42 <<< 4) - (w_p42 <<< 3);
            2'd1:    w_srv_n = SERVO_BASE - (w_r42 <<< 9) + (w_r42 <<< 3) + (w_r42 <<< 2);
            default: w_srv_n = SERVO_BASE - (w_p42 <<< 9) + (w_p42 <<< 3) + (w_p42 <<< 2);
        endcase
    end

    assign w_load_out = (r_state == ST_OUT) && (!r_ov || !i_out_stall);

    // Next state and datapath control
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_cnt   = r_cnt;
        n_count = r_count;
        n_cal   = r_cal;
        n_sum   = r_sum;
        n_off   = r_off;
        n_ang   = r_ang;
        n_inc   = r_inc;
        n_s1    = r_s1;
        n_s2    = r_s2;
        n_s3    = r_s3;
        n_prod  = r_prod;
        n_mcand = r_mcand;
        n_mplr  = r_mplr;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_dsr   = r_dsr;
        n_neg   = r_neg;
        w_start = 1'b0;
        w_dvd   = '0;
        w_dsr_sel = INC_DEN;

        // Advance the divider by one bit
        if (r_state inside {ST_CAL_DIV, ST_INC_DIV, ST_SRV_DIV}) begin
            n_rem = w_ge ? DSR_W'(w_trial - {1'b0, r_dsr}) : DSR_W'(w_trial);
            n_quo = w_quo_fin;
            n_cnt = r_cnt + 1'b1;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    n_idx = 2'd0;
                    if (r_cal) begin
                        n_state = ST_MUL_LD;
                    end else begin
                        for (int k = 0; k < 3; k++) begin
                            n_sum[k] = r_sum[k] + 24'(w_gyr_in[k]);
                        end
                        n_count = r_count + 1'b1;
                        if (n_count >= 8'(CAL_SAMPLES)) begin
                            n_state = ST_CAL_LD;
                        end
                    end
                end
            end
            ST_CAL_LD: begin
                w_start = 1'b1;
                w_dvd = 42'(r_sum[r_idx]);
                w_dsr_sel = DSR_W'(CAL_SAMPLES);
                n_state = ST_CAL_DIV;
            end
            ST_CAL_DIV: begin
                if (w_div_last) begin
                    n_off[r_idx] = 16'(w_q);
                    if (r_idx == 2'd2) begin
                        n_cal = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                        n_state = ST_CAL_LD;
                    end
                end
            end
            ST_MUL_LD: begin
                n_prod  = '0;
                n_mcand = 37'(w_diff);
                n_mplr  = r_el;
                n_cnt   = '0;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_prod  = w_prod_fin;
                n_mcand = r_mcand <<< 1;
                n_mplr  = r_mplr >> 1;
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MUL_W - 1)) begin
                    w_start = 1'b1;
                    w_dvd = 42'(w_prod_fin);
                    w_dsr_sel = INC_DEN;
                    n_state = ST_INC_DIV;
                end
            end
            ST_INC_DIV: begin
                if (w_div_last) begin
                    n_inc = 30'(w_q);
                    n_state = ST_FILT;
                end
            end
            ST_FILT: begin
                n_ang[r_idx] = w_sat;
                if (r_idx == 2'd2) begin
                    n_idx = 2'd0;
                    n_state = ST_SRV_LD;
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_state = ST_MUL_LD;
                end
            end
            ST_SRV_LD: begin
                w_start = 1'b1;
                w_dvd = w_srv_n;
                w_dsr_sel = SERVO_DEN;
                n_state = ST_SRV_DIV;
            end
            ST_SRV_DIV: begin
                if (w_div_last) begin
                    case (r_idx)
                        2'd0: begin
                            n_s1 = (w_q < 42'sd500) ? 12'd500 :
                                   (w_q > 42'sd2500) ? 12'd2500 : 12'(w_q);
                        end
                        2'd1: begin
                            n_s2 = (w_q < 42'sd1000) ? 11'd1000 :
                                   (w_q > 42'sd2000) ? 11'd2000 : 11'(w_q);
                        end
                        default: begin
                            n_s3 = (w_q < 42'sd800) ? 12'd800 :
                                   (w_q > 42'sd2200) ? 12'd2200 : 12'(w_q);
                        end
                    endcase
                    if (r_idx == 2'd2) begin
                        n_state = ST_OUT;
                    end else begin
                        n_idx = r_idx + 1'b1;
                        n_state = ST_SRV_LD;
                    end
                end
            end
            ST_OUT: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Load the divider with the magnitude of the dividend
        if (w_start) begin
            n_rem = '0;
            n_cnt = '0;
            n_dsr = w_dsr_sel;
            n_neg = w_dvd[DIV_W-1];
            n_quo = w_dvd[DIV_W-1] ? DIV_W'(-w_dvd) : DIV_W'(w_dvd);
        end
    end

    // Output valid: set on load, drop on transfer
    always_comb begin
        n_ov = r_ov;
        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end
        if (w_load_out) begin
            n_ov = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_cnt   <= '0;
            r_count <= '0;
            r_cal   <= 1'b0;
            r_ov    <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_sum[k] <= '0;
                r_off[k] <= '0;
                r_ang[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
            r_count <= n_count;
            r_cal   <= n_cal;
            r_ov    <= n_ov;
            r_sum   <= n_sum;
            r_off   <= n_off;
            r_ang   <= n_ang;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_acc[0] <= 16'(-i_accel_x);
            r_acc[1] <= 16'(-i_accel_y);
            r_acc[2] <= i_accel_z;
            r_gyr    <= w_gyr_in;
            r_el     <= i_elapsed_us;
        end
        r_inc   <= n_inc;
        r_s1    <= n_s1;
        r_s2    <= n_s2;
        r_s3    <= n_s3;
        r_prod  <= n_prod;
        r_mcand <= n_mcand;
        r_mplr  <= n_mplr;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_dsr   <= n_dsr;
        r_neg   <= n_neg;
        if (w_load_out) begin
            r_o_ang <= r_ang;
            r_o_s1  <= r_s1;
            r_o_s2  <= r_s2;
            r_o_s3  <= r_s3;
        end
    end

    assign o_out_valid       = r_ov;
    assign o_roll_angle      = r_o_ang[0];
    assign o_pitch_angle     = r_o_ang[1];
    assign o_yaw_angle       = r_o_ang[2];
    assign o_servo_first_us  = r_o_s1;
    assign o_servo_second_us = r_o_s2;
    assign o_servo_third_us  = r_o_s3;

    // Checks
    `IMUCF_ASSERT_ALWAYS(a_cal_holds, !$fell(r_cal), "calibration flag dropped")
    `IMUCF_ASSERT_IMP(a_filter_needs_cal, r_state == ST_MUL_LD, r_cal,
        "filter started before calibration")
    `IMUCF_ASSERT_IMP(a_servo_range, o_out_valid,
        o_servo_first_us >= 12'd500 && o_servo_first_us <= 12'd2500 &&
        o_servo_second_us >= 11'd1000 && o_servo_second_us <= 11'd2000,
        "servo pulse outside clamp")
    `IMUCF_ASSERT_IMP(a_div_count, r_state == ST_INC_DIV || r_state == ST_SRV_DIV,
        r_cnt <= CNT_W'(DIV_W - 1), "divider ran past its length")

endmodule
